>>> rtl/core/rcp_pkg.sv
// rcp_pkg: shared types and constants of the receptor cluster placer
// used by rcp_ctrl, receptor_cluster_placer_core and rcp_checker
`timescale 1ns / 1ps

package rcp_pkg;

  localparam int unsigned MAX_CLUSTERS = 64;
  localparam int unsigned MAX_CAPACITY = 64;
  localparam int unsigned LEVELS       = 5;

  localparam int unsigned CL_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned GLB_W = 13;
  localparam int unsigned THR_W = 33;
  localparam int unsigned RND_W = 32;
  localparam int unsigned LEV_W = 3;
  localparam int unsigned PRD_W = CNT_W + RND_W + 1;

  localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(64);
  localparam logic [CNT_W-1:0] CAP_RST   = CNT_W'(64);
  localparam logic [THR_W-1:0] THR_RST   = THR_W'(858993459);

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_CAP   = 2'd1,
    CFG_THR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_CHECK
  } ctrl_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap;
    logic [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]             fill;
    logic [LEVELS-1:0][CNT_W-1:0] act;
    logic [LEVELS-1:0][CNT_W-1:0] inact;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

>>> rtl/core/rcp_ram.sv
// rcp_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/rcp_ctrl.sv
// rcp_ctrl: placement sequencer, start index, probing, row update and result register
// depends on rcp_pkg; drives the cluster row ram in the top level
`timescale 1ns / 1ps

module rcp_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rcp_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rcp_pkg::LEV_W-1:0]    methylation_level_i,
  input  logic [rcp_pkg::RND_W-1:0]    activity_random_i,
  input  logic [rcp_pkg::RND_W-1:0]    cluster_random_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [5:0]                   placed_cluster_o,
  output logic                         was_active_o,
  output logic                         all_full_o,
  output logic [6:0]                   cluster_fill_o,
  output logic [6:0]                   level_active_count_o,
  output logic [6:0]                   level_inactive_count_o,
  output logic [12:0]                  global_level_active_o,
  output logic                         ram_re_o,
  output logic [rcp_pkg::CL_W-1:0]     ram_addr_o,
  output logic                         ram_we_o,
  output rcp_pkg::row_t                ram_wdata_o,
  input  rcp_pkg::row_t                ram_rdata_i
);
  import rcp_pkg::*;

  ctrl_state_e state_q, state_d;

  logic [LEV_W-1:0] level_q;
  logic             active_q;
  logic             lvl_bad_q;
  logic [PRD_W-1:0] prod_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] cap_q;
  logic [CL_W-1:0]  probe_q, probe_d;
  logic [CNT_W-1:0] k_q;
  logic [MAX_CLUSTERS-1:0] valid_q;
  logic [GLB_W-1:0] glob_q [LEVELS];

  logic             out_valid_q;
  logic [5:0]       res_cl_q;
  logic             res_act_q;
  logic             res_full_q;
  logic [CNT_W-1:0] res_fill_q;
  logic [CNT_W-1:0] res_la_q;
  logic [CNT_W-1:0] res_li_q;
  logic [GLB_W-1:0] res_glb_q;

  logic             in_fire;
  logic             out_free;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] cap_eff;
  logic [PRD_W-1:0] prod_d;
  logic [PRD_W-CNT_W-1:0] clu_inc;
  logic [8:0]       start_raw;
  logic [8:0]       start_max;
  logic [CL_W-1:0]  start_idx;
  row_t             row;
  row_t             row_new;
  logic             found;
  logic             last;
  logic [LVL_W-1:0] lvl;
  logic [GLB_W-1:0] glob_new;

  logic ld_start;
  logic ld_res;
  logic ld_bad;
  logic advance;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    count_eff = cfg_i.count;
    if (cfg_i.count == '0) begin
      count_eff = CNT_W'(1);
    end else if (cfg_i.count > CNT_W'(MAX_CLUSTERS)) begin
      count_eff = CNT_W'(MAX_CLUSTERS);
    end
    cap_eff = cfg_i.cap;
    if (cfg_i.cap > CNT_W'(MAX_CAPACITY)) begin
      cap_eff = CNT_W'(MAX_CAPACITY);
    end
  end

  assign clu_inc = {1'b0, cluster_random_i} + (PRD_W-CNT_W)'(1);
  assign prod_d  = PRD_W'(count_eff) * PRD_W'(clu_inc);

  assign start_raw = 9'(prod_q[PRD_W-1:RND_W]);
  assign start_max = 9'(count_q - CNT_W'(1));
  assign start_idx = (start_raw > start_max) ? CL_W'(start_max) : CL_W'(start_raw);

  assign lvl   = LVL_W'(level_q);
  assign row   = valid_q[probe_q] ? ram_rdata_i : '0;
  assign found = row.fill < cap_q;
  assign last  = (k_q + CNT_W'(1)) == count_q;

  always_comb begin
    row_new = row;
    row_new.fill = row.fill + CNT_W'(1);
    if (active_q) begin
      row_new.act[lvl] = row.act[lvl] + CNT_W'(1);
    end else begin
      row_new.inact[lvl] = row.inact[lvl] + CNT_W'(1);
    end
  end

  assign glob_new = glob_q[lvl] + GLB_W'(active_q);

  always_comb begin
    probe_d = probe_q + CL_W'(1);
    if ((CNT_W'(probe_q) + CNT_W'(1)) >= count_q) begin
      probe_d = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (!lvl_bad_q) begin
          state_d = ST_READ;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (found || last) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    ld_start = 1'b0;
    ld_res   = 1'b0;
    ld_bad   = 1'b0;
    advance  = 1'b0;
    ram_re_o = 1'b0;
    ram_we_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
      end
      ST_START: begin
        ld_start = !lvl_bad_q;
        ld_bad   = lvl_bad_q && out_free;
      end
      ST_READ: begin
        ram_re_o = 1'b1;
      end
      ST_CHECK: begin
        if (found || last) begin
          ld_res   = out_free;
          ram_we_o = out_free && found;
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_addr_o  = probe_q;
  assign ram_wdata_o = row_new;
  assign in_stall_o  = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        glob_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (ram_we_o) begin
        valid_q[probe_q] <= 1'b1;
        glob_q[lvl]      <= glob_new;
      end
      if (ld_res || ld_bad) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      level_q   <= methylation_level_i;
      lvl_bad_q <= methylation_level_i >= LEV_W'(LEVELS);
      active_q  <= (methylation_level_i != '0) &&
                   ({1'b0, activity_random_i} < cfg_i.thr);
      prod_q    <= prod_d;
      count_q   <= count_eff;
      cap_q     <= cap_eff;
    end
    if (ld_start) begin
      probe_q <= start_idx;
      k_q     <= '0;
    end else if (advance) begin
      probe_q <= probe_d;
      k_q     <= k_q + CNT_W'(1);
    end
    if (ld_bad) begin
      res_cl_q   <= '0;
      res_act_q  <= 1'b0;
      res_full_q <= 1'b0;
      res_fill_q <= '0;
      res_la_q   <= '0;
      res_li_q   <= '0;
      res_glb_q  <= '0;
    end else if (ld_res) begin
      if (found) begin
        res_cl_q   <= 6'(probe_q);
        res_act_q  <= active_q;
        res_full_q <= 1'b0;
        res_fill_q <= row_new.fill;
        res_la_q   <= row_new.act[lvl];
        res_li_q   <= row_new.inact[lvl];
        res_glb_q  <= glob_new;
      end else begin
        res_cl_q   <= '0;
        res_act_q  <= 1'b0;
        res_full_q <= 1'b1;
        res_fill_q <= '0;
        res_la_q   <= '0;
        res_li_q   <= '0;
        res_glb_q  <= '0;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign placed_cluster_o       = res_cl_q;
  assign was_active_o           = res_act_q;
  assign all_full_o             = res_full_q;
  assign cluster_fill_o         = res_fill_q;
  assign level_active_count_o   = res_la_q;
  assign level_inactive_count_o = res_li_q;
  assign global_level_active_o  = res_glb_q;

endmodule

>>> rtl/core/receptor_cluster_placer_core.sv
// receptor_cluster_placer_core: top level, configuration registers and cluster row ram
// depends on rcp_pkg, rcp_ram and rcp_ctrl
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   methylation_level, activity_random,
//                                                  cluster_random
//   out       output     out_valid_o / out_stall_i placed_cluster .. global_level_active
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// an item occupies the block for a start step and then a read and a check for each cluster
// probed, and it stays in the check while its result cannot be handed over; each probe uses
// the single read port of the cluster row ram with its registered read
// reset clears the per-row valid bits at once, so there is no clearing pass
// a result waiting under out_stall_i does not block the next transfer on in
`timescale 1ns / 1ps

module receptor_cluster_placer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [rcp_pkg::THR_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 methylation_level_i,
  input  logic [31:0]                activity_random_i,
  input  logic [31:0]                cluster_random_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [5:0]                 placed_cluster_o,
  output logic                       was_active_o,
  output logic                       all_full_o,
  output logic [6:0]                 cluster_fill_o,
  output logic [6:0]                 level_active_count_o,
  output logic [6:0]                 level_inactive_count_o,
  output logic [12:0]                global_level_active_o
);
  import rcp_pkg::*;

  cfg_t            cfg_q;
  logic            ram_re;
  logic            ram_we;
  logic [CL_W-1:0] ram_addr;
  row_t            ram_wdata;
  row_t            ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count <= COUNT_RST;
      cfg_q.cap   <= CAP_RST;
      cfg_q.thr   <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COUNT: cfg_q.count <= cfg_wdata_i[CNT_W-1:0];
        CFG_CAP:   cfg_q.cap   <= cfg_wdata_i[CNT_W-1:0];
        CFG_THR:   cfg_q.thr   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  rcp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  rcp_ctrl u_ctrl (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .methylation_level_i    (methylation_level_i),
    .activity_random_i      (activity_random_i),
    .cluster_random_i       (cluster_random_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .placed_cluster_o       (placed_cluster_o),
    .was_active_o           (was_active_o),
    .all_full_o             (all_full_o),
    .cluster_fill_o         (cluster_fill_o),
    .level_active_count_o   (level_active_count_o),
    .level_inactive_count_o (level_inactive_count_o),
    .global_level_active_o  (global_level_active_o),
    .ram_re_o               (ram_re),
    .ram_addr_o             (ram_addr),
    .ram_we_o               (ram_we),
    .ram_wdata_o            (ram_wdata),
    .ram_rdata_i            (ram_rdata)
  );

endmodule

>>> rtl/core/rcp_checker.sv
// rcp_checker: port-level assertions for receptor_cluster_placer_core
// depends on rcp_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module rcp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic [1:0]                 cfg_idx_i,
  input logic [rcp_pkg::THR_W-1:0]  cfg_wdata_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [2:0]                 methylation_level_i,
  input logic [31:0]                activity_random_i,
  input logic [31:0]                cluster_random_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [5:0]                 placed_cluster_o,
  input logic                       was_active_o,
  input logic                       all_full_o,
  input logic [6:0]                 cluster_fill_o,
  input logic [6:0]                 level_active_count_o,
  input logic [6:0]                 level_inactive_count_o,
  input logic [12:0]                global_level_active_o
);
  import rcp_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the block is busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // nothing placed when every cluster is full
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_full_o |-> placed_cluster_o == '0 && !was_active_o &&
                                  cluster_fill_o == '0 && global_level_active_o == '0)
    else $error("all-full result carries a placement");

  // an active placement bumps both active counts
  a_active_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_active_o |-> level_active_count_o != '0 &&
                                    global_level_active_o != '0 && cluster_fill_o != '0)
    else $error("active placement without counts");

  // per-level counts never exceed the cluster fill
  a_level_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_active_count_o <= cluster_fill_o &&
                    level_inactive_count_o <= cluster_fill_o)
    else $error("level count above cluster fill");

endmodule

bind receptor_cluster_placer_core rcp_checker u_rcp_checker (.*);
